// ===== rtl/core/tbtl_pkg.sv =====
// Shared types and constants of the token bucket transmit limiter.
// No dependencies; every other file of the block refers to this package.

package tbtl_pkg;

    localparam int TICK_W = 32;
    localparam int TOK_W  = 24;
    localparam int RATE_W = 16;
    localparam int SIZE_W = 12;
    localparam int PROD_W = TICK_W + RATE_W;
    // The widest value the shared unit sees is a refill product plus a token count.
    localparam int ALU_W  = PROD_W + 1;

    localparam logic [TICK_W-1:0] GAP_RESET  = 32'd100;
    localparam logic [TOK_W-1:0]  CAP_RESET  = 24'd1024;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TICK_W;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

    typedef enum logic [1:0] {
        ST_ALLOWED  = 2'd0,
        ST_DEFERRED = 2'd1,
        ST_INVALID  = 2'd2,
        ST_LOCKED   = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic             cin;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

// ===== rtl/core/tbtl_alu.sv =====
// Shared add/subtract unit of the token bucket limiter.
// Depends on tbtl_pkg for the request type and the datapath width.

module tbtl_alu (
    input  tbtl_pkg::alu_req_t          req,
    // Top bit is the carry of an add or the borrow of a subtract.
    output logic [tbtl_pkg::ALU_W:0]    res
);

    always_comb
    begin
        case (req.op)
            tbtl_pkg::ALU_ADD:
            begin
                res = {1'b0, req.a} + {1'b0, req.b} + {{tbtl_pkg::ALU_W{1'b0}}, req.cin};
            end
            tbtl_pkg::ALU_SUB:
            begin
                res = {1'b0, req.a} - {1'b0, req.b};
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tbtl_mul.sv =====
// Registered refill multiplier: elapsed ticks times the refill rate.
// Depends on tbtl_pkg for the field widths.

module tbtl_mul (
    input  logic                          clk,
    input  logic [tbtl_pkg::TICK_W-1:0]   elapsed,
    input  logic [tbtl_pkg::RATE_W-1:0]   rate,
    output logic [tbtl_pkg::PROD_W-1:0]   prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= tbtl_pkg::PROD_W'(elapsed) * tbtl_pkg::PROD_W'(rate);
    end

endmodule

// ===== rtl/core/token_bucket_transmit_limiter_unit.sv =====
// Top level of the token bucket transmit limiter: sequencer, state and ports.
// Depends on tbtl_pkg, tbtl_alu and tbtl_mul.

// A byte token bucket with a minimum gap between recorded transmissions. Each input
// transaction carries a command (evaluate or record), a tick and a datagram size and
// yields exactly one result transaction. One item is handled at a time: s_tready is
// high only while the sequencer is idle. An invalid size or a blocked policy goes from
// S_CHECK straight to S_OUT; the longest path adds the compare, refill and cap steps
// and the divide steps of the serial wait divider, which yields D quotient bits, where
// D = clog2(MAX_DATAGRAM + 1). The steps run in turn on the single shared add/subtract
// unit: tick and token compares, refill sum, cap check, divide steps, spend and tick sums.
// A finished result sits in the output register while the next item is accepted.
// Writing MIN_GAP, CAPACITY or RATE refills the bucket and restarts tick tracking.

module token_bucket_transmit_limiter_unit #(
    parameter int MAX_DATAGRAM = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_time [31:0], packet_bytes [43:32], zero fill [47:44]
    input  logic [47:0]                         s_tdata,
    // cmd [0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ready_tick [31:0], tokens_left [55:32]
    output logic [55:0]                         m_tdata,
    // status [1:0], block_valid [2]
    output logic [2:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [tbtl_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [tbtl_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int TICK_W = tbtl_pkg::TICK_W;
    localparam int TOK_W  = tbtl_pkg::TOK_W;
    localparam int RATE_W = tbtl_pkg::RATE_W;
    localparam int SIZE_W = tbtl_pkg::SIZE_W;
    localparam int ALU_W  = tbtl_pkg::ALU_W;
    localparam int DEF_W  = $clog2(MAX_DATAGRAM + 1);
    localparam int CNT_W  = $clog2(DEF_W + 1);
    localparam logic POLICY_RESET = (tbtl_pkg::GAP_RESET != '0) &&
                                    (tbtl_pkg::CAP_RESET >= TOK_W'(MAX_DATAGRAM)) &&
                                    (tbtl_pkg::RATE_RESET != '0);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CMP_LAST,
        S_MUL,
        S_ADD,
        S_CAP,
        S_CMP_GAP,
        S_CMP_TOK,
        S_DIV,
        S_SAT,
        S_SPEND,
        S_GAPSET,
        S_OUT
    } state_t;

    state_t                   state_reg;

    logic [TICK_W-1:0]        gap_reg;
    logic [TOK_W-1:0]         cap_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic [TICK_W-1:0]        gap_next;
    logic [TOK_W-1:0]         cap_next;
    logic [RATE_W-1:0]        rate_next;
    logic                     cfg_hit;
    logic                     policy_next;

    logic [TOK_W-1:0]         tok_reg;
    logic [TICK_W-1:0]        last_reg;
    logic                     running_reg;
    logic [TICK_W-1:0]        next_ok_reg;
    logic                     policy_reg;

    logic                     cmd_reg;
    logic [TICK_W-1:0]        now_reg;
    logic [SIZE_W-1:0]        size_reg;
    tbtl_pkg::status_t        status_reg;
    logic [TICK_W-1:0]        ready_reg;
    logic [TICK_W-1:0]        elapsed_reg;
    logic [ALU_W-1:0]         sum_reg;
    logic [RATE_W-1:0]        rem_reg;
    logic [DEF_W-1:0]         quot_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic                     m_tvalid_reg;
    logic [1:0]               out_status_reg;
    logic [TICK_W-1:0]        out_ready_reg;
    logic                     out_valid_reg;
    logic [TOK_W-1:0]         out_tok_reg;

    tbtl_pkg::alu_req_t       alu_req;
    logic [ALU_W:0]           alu_res;
    logic                     borrow;
    logic [TICK_W-1:0]        sat_tick;
    logic [tbtl_pkg::PROD_W-1:0] prod;
    logic                     size_bad;

    tbtl_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    tbtl_mul u_mul (
        .clk      (clk),
        .elapsed  (elapsed_reg),
        .rate     (rate_reg),
        .prod_reg (prod)
    );

    assign borrow   = alu_res[ALU_W];
    assign sat_tick = (|alu_res[ALU_W:TICK_W]) ? '1 : alu_res[TICK_W-1:0];
    assign size_bad = (size_reg == '0) || (size_reg > SIZE_W'(MAX_DATAGRAM));

    // Register values after a write; a restart takes its policy from these.
    always_comb
    begin
        gap_next  = gap_reg;
        cap_next  = cap_reg;
        rate_next = rate_reg;
        cfg_hit   = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                tbtl_pkg::REG_MIN_GAP:
                begin
                    gap_next = cfg_wr_data;
                    cfg_hit  = 1'b1;
                end
                tbtl_pkg::REG_CAPACITY:
                begin
                    cap_next = cfg_wr_data[TOK_W-1:0];
                    cfg_hit  = 1'b1;
                end
                tbtl_pkg::REG_RATE:
                begin
                    rate_next = cfg_wr_data[RATE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        policy_next = (gap_next != '0) && (cap_next >= TOK_W'(MAX_DATAGRAM)) &&
                      (rate_next != '0);
    end

    // Operand selection for the shared unit, one operation per sequencer step.
    always_comb
    begin
        alu_req.op  = tbtl_pkg::ALU_SUB;
        alu_req.cin = 1'b0;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (state_reg)
            S_CMP_LAST:
            begin
                alu_req.a = ALU_W'(now_reg);
                alu_req.b = ALU_W'(last_reg);
            end
            S_ADD:
            begin
                alu_req.op = tbtl_pkg::ALU_ADD;
                alu_req.a  = ALU_W'(prod);
                alu_req.b  = ALU_W'(tok_reg);
            end
            S_CAP:
            begin
                alu_req.a = sum_reg;
                alu_req.b = ALU_W'(cap_reg);
            end
            S_CMP_GAP:
            begin
                alu_req.a = ALU_W'(now_reg);
                alu_req.b = ALU_W'(next_ok_reg);
            end
            S_CMP_TOK:
            begin
                alu_req.a = ALU_W'(size_reg);
                alu_req.b = ALU_W'(tok_reg);
            end
            S_DIV:
            begin
                alu_req.a = ALU_W'({rem_reg, quot_reg[DEF_W-1]});
                alu_req.b = ALU_W'(rate_reg);
            end
            S_SAT:
            begin
                // Rounding the quotient up rides on the carry input.
                alu_req.op  = tbtl_pkg::ALU_ADD;
                alu_req.cin = (rem_reg != '0);
                alu_req.a   = ALU_W'(now_reg);
                alu_req.b   = ALU_W'(quot_reg);
            end
            S_SPEND:
            begin
                alu_req.a = ALU_W'(tok_reg);
                alu_req.b = ALU_W'(size_reg);
            end
            S_GAPSET:
            begin
                alu_req.op = tbtl_pkg::ALU_ADD;
                alu_req.a  = ALU_W'(now_reg);
                alu_req.b  = ALU_W'(gap_reg);
            end
            default:
            begin
                alu_req.op = tbtl_pkg::ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gap_reg        <= tbtl_pkg::GAP_RESET;
            cap_reg        <= tbtl_pkg::CAP_RESET;
            rate_reg       <= tbtl_pkg::RATE_RESET;
            tok_reg        <= tbtl_pkg::CAP_RESET;
            last_reg       <= '0;
            running_reg    <= 1'b0;
            next_ok_reg    <= '0;
            policy_reg     <= POLICY_RESET;
            cmd_reg        <= 1'b0;
            now_reg        <= '0;
            size_reg       <= '0;
            status_reg     <= tbtl_pkg::ST_INVALID;
            ready_reg      <= '0;
            elapsed_reg    <= '0;
            sum_reg        <= '0;
            rem_reg        <= '0;
            quot_reg       <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= '0;
            out_ready_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_tok_reg    <= '0;
        end
        else
        begin
            // In S_OUT the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                gap_reg     <= gap_next;
                cap_reg     <= cap_next;
                rate_reg    <= rate_next;
                tok_reg     <= cap_next;
                last_reg    <= '0;
                running_reg <= 1'b0;
                next_ok_reg <= '0;
                policy_reg  <= policy_next;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        now_reg   <= s_tdata[TICK_W-1:0];
                        size_reg  <= s_tdata[TICK_W+SIZE_W-1:TICK_W];
                        ready_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!policy_reg || size_bad)
                    begin
                        status_reg <= tbtl_pkg::ST_INVALID;
                        if (cmd_reg)
                        begin
                            policy_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_CMP_LAST;
                    end
                end
                S_CMP_LAST:
                begin
                    if (!running_reg)
                    begin
                        running_reg <= 1'b1;
                        last_reg    <= now_reg;
                        state_reg   <= S_CMP_GAP;
                    end
                    else if (borrow)
                    begin
                        status_reg <= tbtl_pkg::ST_LOCKED;
                        policy_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        elapsed_reg <= alu_res[TICK_W-1:0];
                        state_reg   <= (alu_res[TICK_W-1:0] == '0) ? S_CMP_GAP : S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    sum_reg   <= alu_res[ALU_W-1:0];
                    last_reg  <= now_reg;
                    state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    tok_reg   <= borrow ? sum_reg[TOK_W-1:0] : cap_reg;
                    state_reg <= S_CMP_GAP;
                end
                S_CMP_GAP:
                begin
                    if (borrow)
                    begin
                        status_reg <= tbtl_pkg::ST_DEFERRED;
                        ready_reg  <= next_ok_reg;
                        if (cmd_reg)
                        begin
                            policy_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_CMP_TOK;
                    end
                end
                S_CMP_TOK:
                begin
                    // size - tokens positive means a deficit to wait for.
                    if (!borrow && (alu_res[SIZE_W-1:0] != '0))
                    begin
                        quot_reg  <= alu_res[DEF_W-1:0];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        status_reg <= tbtl_pkg::ST_ALLOWED;
                        ready_reg  <= now_reg;
                        state_reg  <= cmd_reg ? S_SPEND : S_OUT;
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (borrow)
                    begin
                        rem_reg <= {rem_reg[RATE_W-2:0], quot_reg[DEF_W-1]};
                    end
                    else
                    begin
                        rem_reg <= alu_res[RATE_W-1:0];
                    end
                    quot_reg <= DEF_W'({quot_reg, !borrow});
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DEF_W - 1))
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    status_reg <= tbtl_pkg::ST_DEFERRED;
                    ready_reg  <= sat_tick;
                    if (cmd_reg)
                    begin
                        policy_reg <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_SPEND:
                begin
                    tok_reg   <= alu_res[TOK_W-1:0];
                    state_reg <= S_GAPSET;
                end
                S_GAPSET:
                begin
                    next_ok_reg <= sat_tick;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= status_reg;
                        out_ready_reg  <= ready_reg;
                        out_valid_reg  <= policy_reg;
                        out_tok_reg    <= tok_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_tok_reg, out_ready_reg};
    assign m_tuser  = {out_valid_reg, out_status_reg};

`ifndef SYNTH
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("limiter accepted a transaction while busy");

    a_policy_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        !policy_reg && !cfg_wr_en |=> !policy_reg)
        else $error("policy became valid without a configuration write");

    a_tokens_capped : assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg <= cap_reg)
        else $error("token count above bucket capacity");

    a_locked_invalid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == tbtl_pkg::ST_LOCKED) |-> !m_tuser[2])
        else $error("locked result reports a valid policy");
`endif

endmodule

// ===== tb/token_bucket_transmit_limiter_unit_tb.sv =====
// Self-checking testbench for token_bucket_transmit_limiter_unit: a scoreboard class predicts
// every decision from its own copy of the bucket, tasks drive stream and config traffic.
// Depends on tbtl_pkg and the token_bucket_transmit_limiter_unit RTL.

module token_bucket_transmit_limiter_unit_tb;

    localparam int          MAX_PKT      = 255;
    localparam logic        CMD_EVAL     = 1'b0;
    localparam logic        CMD_RECORD   = 1'b1;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_WAIT  = 30;
    localparam int unsigned END_LIMIT    = 20000;
    localparam int unsigned MAX_PRINTED  = 200;

    typedef struct packed {
        tbtl_pkg::status_t status;
        logic [31:0]       ready_tick;
        logic              block_valid;
        logic [23:0]       tokens_left;
    } verdict_t;

    class limiter_scoreboard;
        int unsigned max_pkt;
        int unsigned errors;
        int unsigned results_seen;
        verdict_t    decision_q[$];

        logic [31:0] min_gap;
        logic [23:0] capacity;
        logic [15:0] rate;

        logic [23:0] tokens;
        logic [31:0] last_tick;
        logic        running;
        logic [31:0] next_ok;
        logic        policy_ok;

        function new(int unsigned max_size);
            max_pkt  = max_size;
            errors   = 0;
            results_seen = 0;
            min_gap  = tbtl_pkg::GAP_RESET;
            capacity = tbtl_pkg::CAP_RESET;
            rate     = tbtl_pkg::RATE_RESET;
            restart();
        endfunction

        function void restart();
            tokens    = capacity;
            last_tick = '0;
            running   = 1'b0;
            next_ok   = '0;
            policy_ok = (min_gap != 0) && (capacity >= max_pkt) && (rate != 0);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                tbtl_pkg::REG_MIN_GAP:  min_gap = val;
                tbtl_pkg::REG_CAPACITY: capacity = val[23:0];
                tbtl_pkg::REG_RATE:     rate = val[15:0];
                default:                return;
            endcase
            restart();
        endfunction

        function int unsigned pending();
            return decision_q.size();
        endfunction

        function bit block_ok();
            return policy_ok;
        endfunction

        // Refill the bucket up to now and decide whether size bytes may go out.
        function tbtl_pkg::status_t judge_request(logic [31:0] now, logic [11:0] size,
                                                  output logic [31:0] ready);
            logic [63:0] total;
            logic [63:0] deficit;
            logic [63:0] wait_ticks;
            ready = '0;
            if (!policy_ok || size == 0 || size > max_pkt)
                return tbtl_pkg::ST_INVALID;
            if (running && now < last_tick)
            begin
                policy_ok = 1'b0;
                return tbtl_pkg::ST_LOCKED;
            end
            if (!running)
            begin
                running   = 1'b1;
                last_tick = now;
            end
            else if (now != last_tick)
            begin
                total     = 64'(tokens) + 64'(now - last_tick) * 64'(rate);
                tokens    = (total > 64'(capacity)) ? capacity : total[23:0];
                last_tick = now;
            end
            if (now < next_ok)
            begin
                ready = next_ok;
                return tbtl_pkg::ST_DEFERRED;
            end
            if (tokens < size)
            begin
                // The rate is never zero here, a zero rate keeps the policy invalid.
                deficit    = 64'(size) - 64'(tokens);
                wait_ticks = (deficit + 64'(rate) - 64'd1) / 64'(rate);
                total      = 64'(now) + wait_ticks;
                ready      = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                return tbtl_pkg::ST_DEFERRED;
            end
            ready = now;
            return tbtl_pkg::ST_ALLOWED;
        endfunction

        function verdict_t accept_request(logic cmd, logic [31:0] now, logic [11:0] size);
            verdict_t    v;
            logic [31:0] ready;
            logic [32:0] sum;
            ready = '0;
            if (cmd == CMD_EVAL)
                v.status = judge_request(now, size, ready);
            else if (!policy_ok)
                v.status = tbtl_pkg::ST_INVALID;
            else
            begin
                v.status = judge_request(now, size, ready);
                if (v.status != tbtl_pkg::ST_ALLOWED)
                    policy_ok = 1'b0;
                else
                begin
                    tokens  = tokens - 24'(size);
                    sum     = {1'b0, now} + {1'b0, min_gap};
                    next_ok = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            v.ready_tick  = ready;
            v.block_valid = policy_ok;
            v.tokens_left = tokens;
            decision_q.push_back(v);
            return v;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch in result %0d: %s got %0h expected %0h",
                         results_seen, what, got, want);
        endtask

        task check_decision(logic [55:0] data, logic [2:0] user);
            verdict_t want;
            results_seen++;
            if (decision_q.size() == 0)
            begin
                report("unexpected transaction", 64'(data), 64'd0);
                return;
            end
            want = decision_q.pop_front();
            if (user[1:0] != want.status)
                report("status", 64'(user[1:0]), 64'(want.status));
            if (data[31:0] != want.ready_tick)
                report("ready_tick", 64'(data[31:0]), 64'(want.ready_tick));
            if (user[2] != want.block_valid)
                report("block_valid", 64'(user[2]), 64'(want.block_valid));
            if (data[55:32] != want.tokens_left)
                report("tokens_left", 64'(data[55:32]), 64'(want.tokens_left));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [47:0]                     s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [55:0]                     m_tdata;
    logic [2:0]                      m_tuser;
    logic                            cfg_wr_en;
    logic [tbtl_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [tbtl_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    limiter_scoreboard sb = new(MAX_PKT);

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_asked   = 0;
    int unsigned hold_taken   = 0;
    int unsigned hold_left    = 0;
    int unsigned items_sent   = 0;

    token_bucket_transmit_limiter_unit #(
        .MAX_DATAGRAM (MAX_PKT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_decision(m_tdata, m_tuser);
    end

    initial
    begin
        #10_000_000;
        $display("token_bucket_transmit_limiter_unit_tb failed");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [31:0] now, input logic [11:0] size,
                             output verdict_t predicted);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, size, now};
        do @(posedge clk); while (!s_tready);
        predicted = sb.accept_request(cmd, now, size);
        items_sent++;
    endtask

    // Configuration is only written once the block has delivered every pending decision.
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] advance_tick(logic [31:0] tick);
        logic [32:0] sum;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: sum = {1'b0, tick} + 33'($urandom_range(0, 6));
            6, 7, 8:          sum = {1'b0, tick} + 33'($urandom_range(0, 300));
            default:          sum = {1'b0, tick} + 33'($urandom);
        endcase
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic random_phase(input int unsigned count, input bit with_hold);
        int unsigned phase_end;
        int unsigned seg_end;
        int unsigned dead_left;
        int unsigned k;
        bit          hold_sent;
        logic [31:0] gap;
        logic [31:0] cap;
        logic [31:0] rate;
        logic [31:0] tick;
        logic [31:0] now;
        logic [11:0] size;
        verdict_t    v;
        phase_end = items_sent + count;
        hold_sent = !with_hold;
        while (items_sent < phase_end)
        begin
            gap  = $urandom_range(1, 40);
            cap  = $urandom_range(MAX_PKT, 1500);
            rate = $urandom_range(1, 64);
            case ($urandom_range(0, 15))
                0:
                begin
                    gap  = 32'hFFFF_FFFF;
                    cap  = 32'h00FF_FFFF;
                    rate = 32'h0000_FFFF;
                end
                1: gap = 0;
                2: cap = $urandom_range(0, MAX_PKT - 1);
                3: rate = 0;
                4:
                begin
                    cap  = MAX_PKT;
                    rate = 1;
                end
                5:
                begin
                    rate = $urandom_range(1, 65535);
                    gap  = $urandom;
                end
                6: cap = $urandom_range(MAX_PKT, 32'h00FF_FFFF);
                default: ;
            endcase
            write_cfg(tbtl_pkg::REG_MIN_GAP, gap);
            write_cfg(tbtl_pkg::REG_CAPACITY, {8'($urandom), cap[23:0]});
            write_cfg(tbtl_pkg::REG_RATE, {16'($urandom), rate[15:0]});

            case ($urandom_range(0, 3))
                0:       tick = 0;
                1:       tick = $urandom_range(0, 5000);
                2:       tick = $urandom;
                default: tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            endcase
            seg_end   = items_sent + $urandom_range(20, 100);
            dead_left = $urandom_range(1, 4);

            while (items_sent < seg_end && items_sent < phase_end && dead_left != 0)
            begin
                // Hold the result side off mid-phase while requests keep coming.
                if (!hold_sent && items_sent >= phase_end - count / 2)
                begin
                    hold_asked++;
                    hold_sent = 1'b1;
                end
                if (!sb.block_ok())
                    dead_left--;
                k = $urandom_range(0, 99);
                if (k < 3)
                begin
                    size = ($urandom_range(0, 3) == 0) ? 12'd0
                           : 12'($urandom_range(MAX_PKT + 1, 4095));
                    send_item(1'($urandom_range(0, 1)), tick, size, v);
                end
                else if (k < 5 && tick != 0)
                begin
                    now = $urandom_range(0, tick - 1);
                    send_item(1'($urandom_range(0, 1)), now, 12'($urandom_range(1, MAX_PKT)), v);
                end
                else if (k < 7)
                begin
                    tick = advance_tick(tick);
                    send_item(CMD_RECORD, tick, 12'($urandom_range(1, MAX_PKT)), v);
                end
                else if (k < 9)
                begin
                    now = $urandom;
                    send_item(1'($urandom_range(0, 1)), now, 12'($urandom), v);
                    if (now > tick)
                        tick = now;
                end
                else
                begin
                    // Ask first, then record the transmission when it is allowed.
                    tick = advance_tick(tick);
                    size = 12'($urandom_range(1, MAX_PKT));
                    send_item(CMD_EVAL, tick, size, v);
                    if (v.status == tbtl_pkg::ST_DEFERRED && $urandom_range(0, 1) == 1)
                    begin
                        tick = v.ready_tick;
                        send_item(CMD_EVAL, tick, size, v);
                    end
                    if (v.status == tbtl_pkg::ST_ALLOWED && $urandom_range(0, 3) != 0)
                        send_item(CMD_RECORD, tick, size, v);
                end
            end
        end
    endtask

    initial
    begin
        int unsigned i;
        verdict_t    v;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 17;
        snk_idle_pct = 57;

        // Default settings: gap deferral, bad sizes, then a record that is not allowed.
        send_item(CMD_EVAL,   32'd1000, 12'd255,  v);
        send_item(CMD_RECORD, 32'd1000, 12'd255,  v);
        send_item(CMD_EVAL,   32'd1050, 12'd1,    v);
        send_item(CMD_EVAL,   32'd1100, 12'd0,    v);
        send_item(CMD_EVAL,   32'd1100, 12'd256,  v);
        send_item(CMD_EVAL,   32'd1100, 12'd4095, v);
        send_item(CMD_RECORD, 32'd1100, 12'd255,  v);
        send_item(CMD_RECORD, 32'd1150, 12'd10,   v);
        send_item(CMD_EVAL,   32'd1200, 12'd10,   v);

        // Smallest valid bucket: token deficit, then a tick that goes backwards.
        write_cfg(tbtl_pkg::REG_MIN_GAP, 32'd1);
        write_cfg(tbtl_pkg::REG_CAPACITY, 32'hAB00_00FF);
        write_cfg(tbtl_pkg::REG_RATE, 32'hFFFF_0003);
        send_item(CMD_EVAL,   32'd0, 12'd255, v);
        send_item(CMD_RECORD, 32'd0, 12'd255, v);
        send_item(CMD_EVAL,   32'd1, 12'd10,  v);
        send_item(CMD_EVAL,   32'd4, 12'd10,  v);
        send_item(CMD_EVAL,   32'd3, 12'd10,  v);
        send_item(CMD_EVAL,   32'd5, 12'd10,  v);
        send_item(CMD_RECORD, 32'd5, 12'd10,  v);

        // Each register in turn makes the policy invalid.
        write_cfg(tbtl_pkg::REG_MIN_GAP, 32'd0);
        send_item(CMD_EVAL, 32'd7, 12'd1, v);
        write_cfg(tbtl_pkg::REG_MIN_GAP, 32'd1);
        write_cfg(tbtl_pkg::REG_CAPACITY, 32'd254);
        send_item(CMD_EVAL, 32'd7, 12'd1, v);
        write_cfg(tbtl_pkg::REG_CAPACITY, 32'd255);
        write_cfg(tbtl_pkg::REG_RATE, 32'd0);
        send_item(CMD_EVAL, 32'd7, 12'd1, v);
        write_cfg(tbtl_pkg::REG_RATE, 32'd1);
        write_cfg(REG_UNUSED, 32'hFFFF_FFFF);

        // Near the top of the tick range the deficit wait saturates.
        send_item(CMD_RECORD, 32'hFFFF_FFF0, 12'd255, v);
        send_item(CMD_EVAL,   32'hFFFF_FFF1, 12'd255, v);
        send_item(CMD_RECORD, 32'hFFFF_FFF1, 12'd0,   v);

        // Largest settings: refill is capped at capacity and the gap end saturates.
        write_cfg(tbtl_pkg::REG_MIN_GAP, 32'hFFFF_FFFF);
        write_cfg(tbtl_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
        write_cfg(tbtl_pkg::REG_RATE, 32'hFFFF_FFFF);
        send_item(CMD_RECORD, 32'd5,         12'd1,   v);
        send_item(CMD_EVAL,   32'hFFFF_FFFE, 12'd255, v);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 12'd255, v);

        random_phase(525, 1'b1);
        src_idle_pct = 57;
        snk_idle_pct = 17;
        random_phase(525, 1'b1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(525, 1'b0);

        s_tvalid <= 1'b0;
        for (i = 0; i < END_LIMIT && sb.pending() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("decisions never delivered", 64'(sb.pending()), 64'd0);
        if (sb.errors == 0)
            $display("token_bucket_transmit_limiter_unit_tb passed");
        else
            $display("token_bucket_transmit_limiter_unit_tb failed");
        $finish;
    end

endmodule
